### sv/bfmh_pkg.sv
// ----------------------------------------------------------------------------
// bfmh_pkg
// Shared types and constants for the Bloom filter block.
// ----------------------------------------------------------------------------
package bfmh_pkg;

	localparam int HASH_W      = 64;
	localparam int SIZE_W      = 13;
	localparam int ROUNDS_W    = 5;
	localparam int SET_BITS_W  = 13;
	localparam int CFG_AW      = 2;
	localparam int CFG_DW      = 13;
	localparam int MOD_STEPS   = 64;
	localparam int QUEUE_DEPTH = 2;

	// register indexes on the config port
	localparam logic [CFG_AW-1:0] REG_BIT_ARRAY_SIZE = 2'd0;
	localparam logic [CFG_AW-1:0] REG_HASH_COUNT     = 2'd1;

	localparam logic [SIZE_W-1:0]   SIZE_MIN     = 13'd2;
	localparam logic [SIZE_W-1:0]   SIZE_RESET   = 13'd4093;
	localparam logic [ROUNDS_W-1:0] ROUNDS_RESET = 5'd3;

	typedef enum logic {
		OP_ADD   = 1'b0,
		OP_QUERY = 1'b1
	} op_t;

	// one classified word: operation, hash, clamped modulus and round count
	typedef struct packed {
		op_t                 kind;
		logic [HASH_W-1:0]   hash_code;
		logic [SIZE_W-1:0]   size;
		logic [ROUNDS_W-1:0] rounds;
	} item_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MOD,
		ST_READ,
		ST_LOOK,
		ST_DONE
	} eng_state_t;

endpackage

### sv/bfmh_ram.sv
// ----------------------------------------------------------------------------
// bfmh_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bfmh_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### sv/bfmh_front.sv
// ----------------------------------------------------------------------------
// bfmh_front
// Config registers, input handshake, and classification of each word.
// ----------------------------------------------------------------------------
module bfmh_front #(
	parameter int MAX_BITS   = 4096,
	parameter int MAX_HASHES = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [bfmh_pkg::CFG_AW-1:0]   cfg_addr,
	input  logic [bfmh_pkg::CFG_DW-1:0]   cfg_data,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [bfmh_pkg::HASH_W-1:0]   s_tdata,
	input  logic                          s_tuser,
	input  logic                          eng_ready,
	input  logic                          q_full,
	output logic                          q_push,
	output bfmh_pkg::item_t               q_item
);

	logic [bfmh_pkg::SIZE_W-1:0]   size_q;
	logic [bfmh_pkg::ROUNDS_W-1:0] hashes_q;
	logic [bfmh_pkg::SIZE_W-1:0]   size_eff;
	logic [bfmh_pkg::ROUNDS_W-1:0] rounds_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q   <= bfmh_pkg::SIZE_RESET;
			hashes_q <= bfmh_pkg::ROUNDS_RESET;
		end else if (cfg_we) begin
			if (cfg_addr == bfmh_pkg::REG_BIT_ARRAY_SIZE) begin
				size_q <= cfg_data;
			end else if (cfg_addr == bfmh_pkg::REG_HASH_COUNT) begin
				hashes_q <= cfg_data[bfmh_pkg::ROUNDS_W-1:0];
			end
		end
	end

	// clamp modulus to [2, MAX_BITS] and rounds to MAX_HASHES
	always_comb begin
		if (size_q < bfmh_pkg::SIZE_MIN) begin
			size_eff = bfmh_pkg::SIZE_MIN;
		end else if (32'(size_q) > 32'(MAX_BITS)) begin
			size_eff = bfmh_pkg::SIZE_W'(MAX_BITS);
		end else begin
			size_eff = size_q;
		end
		if (32'(hashes_q) > 32'(MAX_HASHES)) begin
			rounds_eff = bfmh_pkg::ROUNDS_W'(MAX_HASHES);
		end else begin
			rounds_eff = hashes_q;
		end
	end

	assign s_tready         = eng_ready & ~q_full;
	assign q_push           = s_tvalid & s_tready;
	assign q_item.kind      = bfmh_pkg::op_t'(s_tuser);
	assign q_item.hash_code = s_tdata;
	assign q_item.size      = size_eff;
	assign q_item.rounds    = rounds_eff;

endmodule

### sv/bfmh_queue.sv
// ----------------------------------------------------------------------------
// bfmh_queue
// Short FIFO of classified words between front and engine.
// ----------------------------------------------------------------------------
module bfmh_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  bfmh_pkg::item_t push_item,
	output logic            full,
	input  logic            pop,
	output logic            valid,
	output bfmh_pkg::item_t pop_item
);

	localparam int PW = $clog2(bfmh_pkg::QUEUE_DEPTH);
	localparam int CW = $clog2(bfmh_pkg::QUEUE_DEPTH + 1);

	bfmh_pkg::item_t entry_q [bfmh_pkg::QUEUE_DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   cnt_q;

	assign full     = (cnt_q == CW'(bfmh_pkg::QUEUE_DEPTH));
	assign valid    = (cnt_q != '0);
	assign pop_item = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (32'(wr_ptr_q) == bfmh_pkg::QUEUE_DEPTH - 1) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (32'(rd_ptr_q) == bfmh_pkg::QUEUE_DEPTH - 1) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

### sv/bfmh_engine.sv
// ----------------------------------------------------------------------------
// bfmh_engine
// Back end: bit-serial modulo, bit store access, set-bit count, result word.
// ----------------------------------------------------------------------------
module bfmh_engine #(
	parameter int MAX_BITS = 4096
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              q_valid,
	input  bfmh_pkg::item_t                   q_item,
	output logic                              q_pop,
	output logic                              ready,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              out_present,
	output logic [bfmh_pkg::SET_BITS_W-1:0]   out_set_bits
);

	localparam int AW = $clog2(MAX_BITS);
	localparam int CW = $clog2(MAX_BITS + 1);
	localparam int SW = bfmh_pkg::SIZE_W;
	localparam int HW = bfmh_pkg::HASH_W;
	localparam int RW = bfmh_pkg::ROUNDS_W;
	localparam int MW = $clog2(bfmh_pkg::MOD_STEPS);
	localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_BITS - 1);
	localparam logic [MW-1:0] LAST_STEP = MW'(bfmh_pkg::MOD_STEPS - 1);

	bfmh_pkg::eng_state_t state_q, state_d;

	logic [AW-1:0]   clr_q;
	logic [CW-1:0]   count_q;
	logic            out_valid_q;
	logic            out_present_q;
	logic [bfmh_pkg::SET_BITS_W-1:0] out_count_q;

	bfmh_pkg::op_t   kind_q;
	logic [HW-1:0]   hash_q;
	logic [HW-1:0]   sum_q;
	logic [HW-1:0]   div_q;
	logic [SW-1:0]   size_q;
	logic [SW-1:0]   rem_q;
	logic [RW-1:0]   rounds_q;
	logic [RW-1:0]   round_q;
	logic [MW-1:0]   step_q;
	logic            present_q;

	logic            we;
	logic [AW-1:0]   waddr;
	logic            wdata;
	logic [AW-1:0]   pos;
	logic            rdata;
	logic            out_free;
	logic            last_round;
	logic            miss;
	logic [SW:0]     rem_shift;
	logic [SW:0]     rem_sub;
	logic [SW-1:0]   rem_next;
	logic [HW-1:0]   sum_next;
	logic [31:0]     rem_ext;
	logic [31:0]     cnt_ext;

	// restoring remainder step: one dividend bit per cycle
	assign rem_shift = {rem_q, div_q[HW-1]};
	assign rem_sub   = rem_shift - {1'b0, size_q};
	assign rem_next  = (rem_shift >= {1'b0, size_q}) ? rem_sub[SW-1:0] : rem_shift[SW-1:0];
	assign sum_next  = sum_q + hash_q;
	assign rem_ext   = 32'(rem_q);
	assign pos       = rem_ext[AW-1:0];
	assign cnt_ext   = 32'(count_q);

	assign out_free   = ~out_valid_q | out_ready;
	assign last_round = (RW'(round_q + RW'(1)) == rounds_q);
	assign miss       = ~rdata;

	bfmh_ram #(.WIDTH(1), .DEPTH(MAX_BITS)) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (pos),
		.rdata (rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bfmh_pkg::ST_CLEAR: begin
				if (clr_q == LAST_ADDR) begin
					state_d = bfmh_pkg::ST_IDLE;
				end
			end
			bfmh_pkg::ST_IDLE: begin
				if (q_valid) begin
					state_d = (q_item.rounds == '0) ? bfmh_pkg::ST_DONE : bfmh_pkg::ST_MOD;
				end
			end
			bfmh_pkg::ST_MOD: begin
				if (step_q == LAST_STEP) begin
					state_d = bfmh_pkg::ST_READ;
				end
			end
			bfmh_pkg::ST_READ: begin
				state_d = bfmh_pkg::ST_LOOK;
			end
			bfmh_pkg::ST_LOOK: begin
				if ((kind_q == bfmh_pkg::OP_QUERY && miss) || last_round) begin
					state_d = bfmh_pkg::ST_DONE;
				end else begin
					state_d = bfmh_pkg::ST_MOD;
				end
			end
			bfmh_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = bfmh_pkg::ST_IDLE;
				end
			end
			default: state_d = bfmh_pkg::ST_CLEAR;
		endcase
	end

	// outputs
	always_comb begin
		q_pop = 1'b0;
		ready = 1'b1;
		we    = 1'b0;
		waddr = pos;
		wdata = 1'b1;
		unique case (state_q)
			bfmh_pkg::ST_CLEAR: begin
				ready = 1'b0;
				we    = 1'b1;
				waddr = clr_q;
				wdata = 1'b0;
			end
			bfmh_pkg::ST_IDLE: begin
				q_pop = q_valid;
			end
			bfmh_pkg::ST_LOOK: begin
				we = (kind_q == bfmh_pkg::OP_ADD) && miss;
			end
			bfmh_pkg::ST_MOD, bfmh_pkg::ST_READ, bfmh_pkg::ST_DONE: begin
				we = 1'b0;
			end
			default: ready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bfmh_pkg::ST_CLEAR;
			clr_q       <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == bfmh_pkg::ST_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (state_q == bfmh_pkg::ST_LOOK && kind_q == bfmh_pkg::OP_ADD && miss) begin
				count_q <= count_q + CW'(1);
			end
			if (state_q == bfmh_pkg::ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			bfmh_pkg::ST_IDLE: begin
				kind_q    <= q_item.kind;
				hash_q    <= q_item.hash_code;
				sum_q     <= q_item.hash_code;
				div_q     <= q_item.hash_code;
				size_q    <= q_item.size;
				rounds_q  <= q_item.rounds;
				rem_q     <= '0;
				step_q    <= '0;
				round_q   <= '0;
				present_q <= (q_item.kind == bfmh_pkg::OP_QUERY);
			end
			bfmh_pkg::ST_MOD: begin
				rem_q  <= rem_next;
				div_q  <= {div_q[HW-2:0], 1'b0};
				step_q <= step_q + MW'(1);
			end
			bfmh_pkg::ST_LOOK: begin
				if (kind_q == bfmh_pkg::OP_QUERY && miss) begin
					present_q <= 1'b0;
				end
				sum_q   <= sum_next;
				div_q   <= sum_next;
				rem_q   <= '0;
				step_q  <= '0;
				round_q <= round_q + RW'(1);
			end
			bfmh_pkg::ST_DONE: begin
				if (out_free) begin
					out_present_q <= present_q;
					out_count_q   <= cnt_ext[bfmh_pkg::SET_BITS_W-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid    = out_valid_q;
	assign out_present  = out_present_q;
	assign out_set_bits = out_count_q;

endmodule

### sv/bloom_filter_multiple_hash.sv
// ----------------------------------------------------------------------------
// bloom_filter_multiple_hash
// Bloom filter with double-hashed bit positions over an on-chip bit store.
// ----------------------------------------------------------------------------
// Each input word is an add (tuser = 0) or a query (tuser = 1) with a 64-bit
// hash code in tdata. Bit positions are (h + i*h) mod bit_array_size for
// i = 0 .. hash_count-1, sum wrapping at 64 bits. An add sets those bits; a
// query reports present when all of them are set and stops at the first
// clear one. Every input word yields exactly one output word carrying the
// present flag (always 0 for an add) and the number of set bits after the
// word. Timing: after reset the store is swept clear, one bit per cycle;
// s_tready stays low meanwhile, config writes are still taken. Each round of
// a word runs the bit-serial remainder unit over the whole hash, then a store
// read, then an update; a query that hits a clear bit ends early. The single
// shared remainder unit sets the pace. The front end keeps taking words into
// a two-entry queue while the engine works, and the result register lets the
// engine finish while a result waits on m_tready. Config values:
// bit_array_size below 2 acts as 2, above MAX_BITS as MAX_BITS; hash_count
// above MAX_HASHES acts as MAX_HASHES, and 0 makes an add a no-op and a
// query report present. Changing the size does not clear the store.
// Write config only while the block is idle.
// ----------------------------------------------------------------------------
module bloom_filter_multiple_hash #(
	parameter int MAX_BITS   = 4096,
	parameter int MAX_HASHES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// config write port: 0 bit_array_size, 1 hash_count
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [12:0] cfg_data,
	// input words
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // [63:0] hash_code
	input  logic        s_tuser,   // [0] kind (0 add, 1 query)
	// result words
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // [0] present, [13:1] set_bits, [15:14] zero
);

	bfmh_pkg::item_t push_item;
	bfmh_pkg::item_t pop_item;
	logic            push;
	logic            pop;
	logic            q_full;
	logic            q_valid;
	logic            eng_ready;
	logic            present;
	logic [12:0]     set_bits;

	// front: config regs, handshake, clamping of size and rounds
	bfmh_front #(
		.MAX_BITS   (MAX_BITS),
		.MAX_HASHES (MAX_HASHES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.eng_ready (eng_ready),
		.q_full    (q_full),
		.q_push    (push),
		.q_item    (push_item)
	);

	// decouples front from the multi-cycle engine
	bfmh_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.valid     (q_valid),
		.pop_item  (pop_item)
	);

	// back: remainder unit, bit store, set-bit count, result register
	bfmh_engine #(
		.MAX_BITS (MAX_BITS)
	) u_engine (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_item       (pop_item),
		.q_pop        (pop),
		.ready        (eng_ready),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_present  (present),
		.out_set_bits (set_bits)
	);

	assign m_tdata = {2'b00, set_bits, present};

endmodule

### verif/tb_bloom_filter_multiple_hash.sv
// ----------------------------------------------------------------------------
// tb_bloom_filter_multiple_hash
// Self-checking bench for the double-hashed Bloom filter.
// ----------------------------------------------------------------------------
// Adds and queries are fed from a request queue. A bit-exact filter model in
// the bench predicts present and set_bits for every accepted word, and each
// result word is checked in order. The register settings change between
// phases, but only once all pending answers are back. Both stream sides
// stall in random bursts, except in the phases whose odds are zero, the closing one among them.
// ----------------------------------------------------------------------------
module tb_bloom_filter_multiple_hash;

	localparam int FILTER_BITS  = 4096;  // matches MAX_BITS of the dut
	localparam int FILTER_HASH  = 16;    // matches MAX_HASHES of the dut
	// Bound on the gap between moved words; it covers the store clear after reset,
	// or one 16-round word plus a stall burst, several times over.
	localparam int STALL_LIMIT  = 20000;
	localparam int SETTLE_WAIT  = 4;     // idle cycles before a register write
	localparam int TAIL_CYCLES  = 1200;  // one slow word's worth after draining

	// write indexes beyond the two registers; the dut must ignore them
	localparam logic [bfmh_pkg::CFG_AW-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [bfmh_pkg::CFG_AW-1:0] REG_SPARE_3 = 2'd3;

	typedef enum logic [1:0] {
		REQ_WORD,   // one add or query
		REQ_WRITE,  // register write, taken once the dut is idle
		REQ_DRAIN   // hold off until every answer is back
	} req_kind_t;

	typedef struct {
		req_kind_t                       what;
		bfmh_pkg::op_t                   op;
		logic [bfmh_pkg::HASH_W-1:0]     code;
		logic [bfmh_pkg::CFG_AW-1:0]     addr;
		logic [bfmh_pkg::CFG_DW-1:0]     data;
		int                              idle_pct;
	} filter_req_t;

	typedef struct packed {
		logic                                present;
		logic [bfmh_pkg::SET_BITS_W-1:0]     set_bits;
	} answer_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        cfg_we   = 1'b0;
	logic [1:0]  cfg_addr = '0;
	logic [12:0] cfg_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata  = '0;   // [63:0] hash_code
	logic        s_tuser  = 1'b0; // [0] kind (0 add, 1 query)
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;         // [0] present, [13:1] set_bits

	// bench copy of the filter
	logic [FILTER_BITS-1:0]              filter_bits = '0;
	logic [bfmh_pkg::SET_BITS_W-1:0]     filter_count = '0;
	logic [bfmh_pkg::SIZE_W-1:0]         size_reg = bfmh_pkg::SIZE_RESET;
	logic [bfmh_pkg::ROUNDS_W-1:0]       rounds_reg = bfmh_pkg::ROUNDS_RESET;

	filter_req_t                 requests_todo[$];
	answer_t                     answers_due[$];
	logic [bfmh_pkg::HASH_W-1:0] added_codes[$];

	logic drained   = 1'b1;  // no answer pending as of the previous edge
	int   idle_now  = 0;     // burst odds of the phase now on the wire
	int   phase_idle = 0;
	int   tx_gap    = 0;
	int   rx_gap    = 0;
	int   settle    = 0;
	int   stall_cycles = 0;
	int   mismatches = 0;

	bloom_filter_multiple_hash dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Run one word through the bench filter; sum wraps at 64 bits, a query
	// stops at the first clear bit.
	function automatic answer_t apply_to_filter(bfmh_pkg::op_t op,
	                                            logic [bfmh_pkg::HASH_W-1:0] code);
		logic [bfmh_pkg::HASH_W-1:0] modulus;
		logic [bfmh_pkg::HASH_W-1:0] sum;
		int                          rounds;
		int                          pos;
		answer_t                     ans;
		modulus = (size_reg < 2) ? 64'd2 :
		          (size_reg > FILTER_BITS) ? 64'(FILTER_BITS) : 64'(size_reg);
		rounds  = (rounds_reg > FILTER_HASH) ? FILTER_HASH : int'(rounds_reg);
		sum     = code;
		ans.present = (op == bfmh_pkg::OP_QUERY);
		for (int i = 0; i < rounds && (op == bfmh_pkg::OP_ADD || ans.present); i++) begin
			pos = int'(sum % modulus);
			if (!filter_bits[pos]) begin
				if (op == bfmh_pkg::OP_ADD) begin
					filter_bits[pos] = 1'b1;
					filter_count = filter_count + bfmh_pkg::SET_BITS_W'(1);
				end else begin
					ans.present = 1'b0;
				end
			end
			sum = sum + code;
		end
		ans.set_bits = filter_count;
		return ans;
	endfunction

	task automatic report_mismatch(string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		mismatches++;
	endtask

	// ---------------------------------------------------------------- driver
	// One nonblocking update per signal per edge: next values are worked out
	// first, then assigned together.
	always @(posedge clk) begin : drive_proc
		filter_req_t req;
		logic        nv;
		logic        nwe;
		logic [1:0]  naddr;
		logic [12:0] ndata;
		logic [63:0] ncode;
		logic        nuser;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			cfg_we   <= 1'b0;
		end else begin
			nv    = s_tvalid && !s_tready;  // word still waiting
			nwe   = 1'b0;
			naddr = cfg_addr;
			ndata = cfg_data;
			ncode = s_tdata;
			nuser = s_tuser;
			if (!nv) begin
				if (tx_gap > 0) begin
					tx_gap--;
				end else if (requests_todo.size() != 0) begin
					req = requests_todo[0];
					case (req.what)
						REQ_WORD: begin
							if ($urandom_range(0, 99) < req.idle_pct) begin
								tx_gap = $urandom_range(0, 11);
							end else begin
								void'(requests_todo.pop_front());
								nv    = 1'b1;
								ncode = req.code;
								nuser = req.op;
								idle_now <= req.idle_pct;
							end
						end
						REQ_WRITE: begin
							// idle: nothing offered this edge, nothing pending
							if (!s_tvalid && drained) begin
								if (settle < SETTLE_WAIT) begin
									settle++;
								end else begin
									settle = 0;
									void'(requests_todo.pop_front());
									nwe   = 1'b1;
									naddr = req.addr;
									ndata = req.data;
									case (req.addr)
										bfmh_pkg::REG_BIT_ARRAY_SIZE: size_reg = req.data;
										bfmh_pkg::REG_HASH_COUNT:
											rounds_reg = req.data[bfmh_pkg::ROUNDS_W-1:0];
										default: ;
									endcase
								end
							end
						end
						REQ_DRAIN: begin
							if (!s_tvalid && drained)
								void'(requests_todo.pop_front());
						end
						default: void'(requests_todo.pop_front());
					endcase
				end
			end
			s_tvalid <= nv;
			s_tdata  <= ncode;
			s_tuser  <= nuser;
			cfg_we   <= nwe;
			cfg_addr <= naddr;
			cfg_data <= ndata;
		end
	end

	// ------------------------------------------------------------- receiver
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (rx_gap > 0) begin
			rx_gap--;
			m_tready <= 1'b0;
		end else if ($urandom_range(0, 99) < idle_now) begin
			rx_gap = $urandom_range(0, 11);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// -------------------------------------------------------------- monitor
	// Result is checked before the new word is predicted, so a result can
	// never be matched against the word taken at the same edge.
	always @(posedge clk) begin : watch_proc
		answer_t got;
		answer_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got.present  = m_tdata[0];
				got.set_bits = m_tdata[13:1];
				if (answers_due.size() == 0) begin
					report_mismatch($sformatf("result word with nothing pending: %h", m_tdata));
				end else begin
					want = answers_due.pop_front();
					if (got.present !== want.present)
						report_mismatch($sformatf("present %b, expected %b",
							got.present, want.present));
					if (got.set_bits !== want.set_bits)
						report_mismatch($sformatf("set_bits %0d, expected %0d",
							got.set_bits, want.set_bits));
				end
			end
			if (s_tvalid && s_tready)
				answers_due.push_back(apply_to_filter(bfmh_pkg::op_t'(s_tuser), s_tdata));
			drained <= (answers_due.size() == 0);
		end
	end

	// ------------------------------------------------------------- watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("timeout: no word moved for %0d cycles", STALL_LIMIT);
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------- stimulus
	task automatic queue_word(bfmh_pkg::op_t op, logic [bfmh_pkg::HASH_W-1:0] code);
		filter_req_t req;
		req.what     = REQ_WORD;
		req.op       = op;
		req.code     = code;
		req.addr     = '0;
		req.data     = '0;
		req.idle_pct = phase_idle;
		requests_todo.push_back(req);
		if (op == bfmh_pkg::OP_ADD)
			added_codes.push_back(code);
	endtask

	task automatic queue_write(logic [bfmh_pkg::CFG_AW-1:0] addr,
	                           logic [bfmh_pkg::CFG_DW-1:0] data);
		filter_req_t req;
		req.what     = REQ_WRITE;
		req.op       = bfmh_pkg::OP_ADD;
		req.code     = '0;
		req.addr     = addr;
		req.data     = data;
		req.idle_pct = phase_idle;
		requests_todo.push_back(req);
	endtask

	task automatic queue_drain();
		filter_req_t req;
		req.what     = REQ_DRAIN;
		req.op       = bfmh_pkg::OP_ADD;
		req.code     = '0;
		req.addr     = '0;
		req.data     = '0;
		req.idle_pct = phase_idle;
		requests_todo.push_back(req);
	endtask

	// hash codes: half full random, plus small, near-max and one-hot values
	function automatic logic [bfmh_pkg::HASH_W-1:0] pick_code();
		case ($urandom_range(0, 5))
			0:       return 64'($urandom_range(0, 4095));
			1:       return ~64'($urandom_range(0, 4095));
			2:       return 64'd1 << $urandom_range(0, 63);
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// New adds, queries of earlier adds (these reach the all-set path), and
	// queries of fresh codes; a drain midway.
	task automatic queue_phase(logic [bfmh_pkg::SIZE_W-1:0] size,
	                           logic [bfmh_pkg::ROUNDS_W-1:0] rounds,
	                           int count, int idle);
		logic [7:0] junk;
		int         pick;
		junk = 8'($urandom);
		phase_idle = idle;
		queue_write(bfmh_pkg::REG_BIT_ARRAY_SIZE, size);
		queue_write(bfmh_pkg::REG_HASH_COUNT, {junk, rounds});  // upper bits are don't-care
		for (int k = 0; k < count; k++) begin
			pick = $urandom_range(0, 99);
			if (pick < 40 || added_codes.size() == 0)
				queue_word(bfmh_pkg::OP_ADD, pick_code());
			else if (pick < 75)
				queue_word(bfmh_pkg::OP_QUERY,
				           added_codes[$urandom_range(0, added_codes.size() - 1)]);
			else
				queue_word(bfmh_pkg::OP_QUERY, pick_code());
			if (k == count / 2)
				queue_drain();
		end
	endtask

	initial begin
		// directed: reset settings first (size 4093, 3 rounds)
		phase_idle = 25;
		queue_word(bfmh_pkg::OP_QUERY, 64'h0);                   // empty store
		queue_word(bfmh_pkg::OP_ADD,   64'h0);                   // every round hits bit 0
		queue_word(bfmh_pkg::OP_QUERY, 64'h0);
		queue_word(bfmh_pkg::OP_ADD,   64'hFFFF_FFFF_FFFF_FFFF); // sum wraps each round
		queue_word(bfmh_pkg::OP_QUERY, 64'hFFFF_FFFF_FFFF_FFFF);
		queue_word(bfmh_pkg::OP_QUERY, 64'h1);
		queue_word(bfmh_pkg::OP_ADD,   64'h8000_0000_0000_0000);
		queue_word(bfmh_pkg::OP_QUERY, 64'h8000_0000_0000_0000);
		queue_word(bfmh_pkg::OP_ADD,   64'h0123_4567_89AB_CDEF);
		queue_word(bfmh_pkg::OP_QUERY, 64'h0123_4567_89AB_CDEF);
		// zero rounds: add changes nothing, query says present
		queue_write(bfmh_pkg::REG_HASH_COUNT, 13'd0);
		queue_word(bfmh_pkg::OP_ADD,   64'hDEAD_BEEF_0000_0001);
		queue_word(bfmh_pkg::OP_QUERY, 64'hDEAD_BEEF_0000_0001);
		// upper data bits dropped: 0x1FF0 leaves 16 rounds
		queue_write(bfmh_pkg::REG_HASH_COUNT, 13'h1FF0);
		queue_word(bfmh_pkg::OP_ADD,   64'hA5A5_A5A5_A5A5_A5A5);
		queue_word(bfmh_pkg::OP_QUERY, 64'hA5A5_A5A5_A5A5_A5A5);
		queue_word(bfmh_pkg::OP_QUERY, 64'h5A5A_5A5A_5A5A_5A5A);
		// round count above the maximum clamps to 16
		queue_write(bfmh_pkg::REG_HASH_COUNT, 13'd31);
		queue_word(bfmh_pkg::OP_QUERY, 64'hA5A5_A5A5_A5A5_A5A5);
		// size 0 and 1 act as 2; store keeps bits above the new size
		queue_write(bfmh_pkg::REG_BIT_ARRAY_SIZE, 13'd0);
		queue_write(bfmh_pkg::REG_HASH_COUNT, 13'd2);
		queue_word(bfmh_pkg::OP_ADD,   64'h1);
		queue_word(bfmh_pkg::OP_QUERY, 64'h3);
		queue_write(bfmh_pkg::REG_BIT_ARRAY_SIZE, 13'd1);
		queue_word(bfmh_pkg::OP_QUERY, 64'h0);
		// size above the store clamps to 4096
		queue_write(bfmh_pkg::REG_BIT_ARRAY_SIZE, 13'h1FFF);
		queue_word(bfmh_pkg::OP_ADD,   64'hFFFF_FFFF_FFFF_FFFF);
		queue_word(bfmh_pkg::OP_QUERY, 64'hFFFF_FFFF_FFFF_FFFF);
		// writes to unused indexes do nothing
		queue_write(REG_SPARE_2, 13'h1FFF);
		queue_write(REG_SPARE_3, 13'h0);
		queue_word(bfmh_pkg::OP_QUERY, 64'h0123_4567_89AB_CDEF);
		queue_write(bfmh_pkg::REG_BIT_ARRAY_SIZE, 13'd4096);
		queue_word(bfmh_pkg::OP_ADD,   64'h0F0F_0F0F_F0F0_F0F0);
		queue_word(bfmh_pkg::OP_QUERY, 64'h0F0F_0F0F_F0F0_F0F0);

		// random phases; small sizes fill up so queries come back present
		queue_phase(13'd4093, 5'd3,  60, 20);
		queue_phase(13'd31,   5'd4,  60, 30);
		queue_phase(13'd2,    5'd1,  20, 15);
		queue_phase(13'd4096, 5'd16, 30, 10);
		queue_phase(13'h1FFF, 5'd8,  40, 0);
		queue_phase(13'd1000, 5'd0,  20, 40);
		queue_phase(13'd97,   5'd5,  60, 25);
		queue_phase(13'd4093, 5'd2,  70, 20);
		queue_phase(13'd511,  5'd31, 30, 15);
		queue_phase(13'd1,    5'd2,  20, 30);
		queue_phase(13'd257,  5'd3, 110, 0);   // closing stretch, no stalls

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		do @(posedge clk);
		while (requests_todo.size() != 0 || s_tvalid || !drained);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (answers_due.size() != 0)
			report_mismatch($sformatf("%0d answers never arrived", answers_due.size()));
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

### filelist.f
sv/bfmh_pkg.sv
sv/bfmh_ram.sv
sv/bfmh_front.sv
sv/bfmh_queue.sv
sv/bfmh_engine.sv
sv/bloom_filter_multiple_hash.sv
verif/tb_bloom_filter_multiple_hash.sv
